@@ hw/rtl/bfr_pkg.sv @@
`timescale 1ns / 1ps

package bfr_pkg;

	localparam int unsigned DATA_W = 25;
	localparam int unsigned ACC_W = 32;
	localparam int unsigned HELD_W = 6;
	localparam int unsigned EW_W = 5;
	localparam int unsigned CNT_W = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_PACK_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BITS = 1'd1;

	localparam logic [HELD_W-1:0] BYTE_BITS = 6'd8;
	localparam logic [HELD_W-1:0] ACC_FULL = 6'd32;
	localparam logic [DATA_W-1:0] BYTE_MASK = 25'h00000FF;
	localparam logic [EW_W-1:0] MIN_ELEM = 5'd8;
	localparam logic [EW_W-1:0] MAX_ELEM = 5'd25;
	localparam logic [EW_W-1:0] ELEM_RESET = 5'd20;

	typedef struct packed {
		logic [DATA_W-1:0] data_in;
		logic block_start;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic last;
	} result_t;

	// one accepted transaction worth of pending results
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [HELD_W-1:0] ptr;
		logic [CNT_W-1:0] cnt;
		logic pack;
		logic [EW_W-1:0] w;
	} job_t;

	function automatic logic [ACC_W-1:0] elem_mask(input logic [EW_W-1:0] w);
		elem_mask = ~({ACC_W{1'b1}} << w);
	endfunction

endpackage

@@ hw/rtl/bfr_front.sv @@
`timescale 1ns / 1ps

module bfr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic item_valid,
	input  logic item_stall,
	input  bfr_pkg::item_t item,
	output logic job_valid,
	output bfr_pkg::job_t job
);

	logic pack_mode_q;
	logic [bfr_pkg::EW_W-1:0] element_bits_q;
	logic [bfr_pkg::ACC_W-1:0] acc_q;
	logic [bfr_pkg::HELD_W-1:0] held_q;

	logic [bfr_pkg::EW_W-1:0] w;
	logic [bfr_pkg::ACC_W-1:0] mask32;
	logic [bfr_pkg::ACC_W-1:0] acc_base;
	logic [bfr_pkg::HELD_W-1:0] held_base;
	logic [bfr_pkg::ACC_W-1:0] data32;
	logic [bfr_pkg::ACC_W-1:0] acc_next;
	logic [bfr_pkg::HELD_W:0] sum;
	logic [bfr_pkg::HELD_W-1:0] held_sat;
	logic [bfr_pkg::HELD_W-1:0] held_next;
	logic [bfr_pkg::CNT_W-1:0] cnt;
	logic accept;

	always_comb begin
		// saturate width into the legal range
		if (element_bits_q < bfr_pkg::MIN_ELEM) begin
			w = bfr_pkg::MIN_ELEM;
		end else if (element_bits_q > bfr_pkg::MAX_ELEM) begin
			w = bfr_pkg::MAX_ELEM;
		end else begin
			w = element_bits_q;
		end
		mask32 = bfr_pkg::elem_mask(w);
		acc_base = item.block_start ? '0 : acc_q;
		held_base = item.block_start ? '0 : held_q;
		data32 = {{(bfr_pkg::ACC_W - bfr_pkg::DATA_W){1'b0}}, item.data_in};
		if (pack_mode_q) begin
			acc_next = (acc_base << w) | (data32 & mask32);
			sum = {1'b0, held_base} + {2'b00, w};
		end else begin
			acc_next = {acc_base[bfr_pkg::ACC_W-9:0], item.data_in[7:0]};
			sum = {1'b0, held_base} + {1'b0, bfr_pkg::BYTE_BITS};
		end
		held_sat = (sum > {1'b0, bfr_pkg::ACC_FULL}) ? bfr_pkg::ACC_FULL
			: sum[bfr_pkg::HELD_W-1:0];
		if (pack_mode_q) begin
			cnt = held_sat[5:3];
			held_next = {3'b000, held_sat[2:0]};
		end else if (held_sat >= {1'b0, w}) begin
			cnt = 3'd1;
			held_next = held_sat - {1'b0, w};
		end else begin
			cnt = 3'd0;
			held_next = held_sat;
		end
	end

	assign accept = item_valid && !item_stall;
	assign job_valid = accept && (cnt != 3'd0);
	assign job.acc = acc_next;
	assign job.ptr = held_sat;
	assign job.cnt = cnt;
	assign job.pack = pack_mode_q;
	assign job.w = w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_mode_q <= 1'b0;
			element_bits_q <= bfr_pkg::ELEM_RESET;
			acc_q <= '0;
			held_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bfr_pkg::CFG_PACK_MODE: pack_mode_q <= cfg_data[0];
					bfr_pkg::CFG_ELEMENT_BITS: element_bits_q <= cfg_data;
				endcase
			end
			if (accept) begin
				acc_q <= acc_next;
				held_q <= held_next;
			end
		end
	end

endmodule

@@ hw/rtl/bfr_emit.sv @@
`timescale 1ns / 1ps

module bfr_emit (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  bfr_pkg::job_t job,
	output logic busy,
	output logic result_valid,
	input  logic result_stall,
	output bfr_pkg::result_t result
);

	logic job_valid_s1;
	bfr_pkg::job_t job_s1;
	logic res_valid_q;
	bfr_pkg::result_t res_q;

	logic move;
	logic last_move;
	logic [bfr_pkg::HELD_W-1:0] step;
	logic [bfr_pkg::HELD_W-1:0] ptr_next;
	logic [bfr_pkg::ACC_W-1:0] shifted;
	logic [bfr_pkg::ACC_W-1:0] wmask;
	logic [bfr_pkg::DATA_W-1:0] mask;

	assign move = job_valid_s1 && (!res_valid_q || !result_stall);
	assign last_move = move && (job_s1.cnt == 3'd1);
	assign busy = job_valid_s1 && !last_move;

	always_comb begin
		step = job_s1.pack ? bfr_pkg::BYTE_BITS : {1'b0, job_s1.w};
		ptr_next = job_s1.ptr - step;
		shifted = job_s1.acc >> ptr_next;
		wmask = bfr_pkg::elem_mask(job_s1.w);
		mask = job_s1.pack ? bfr_pkg::BYTE_MASK : wmask[bfr_pkg::DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (job_valid) begin
				job_valid_s1 <= 1'b1;
			end else if (last_move) begin
				job_valid_s1 <= 1'b0;
			end
			if (move) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid) begin
			job_s1 <= job;
		end else if (move) begin
			job_s1.ptr <= ptr_next;
			job_s1.cnt <= job_s1.cnt - 3'd1;
		end
		if (move) begin
			res_q.data_out <= shifted[bfr_pkg::DATA_W-1:0] & mask;
			res_q.last <= (job_s1.cnt == 3'd1);
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	a_no_empty_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s1 |-> job_s1.cnt != 3'd0)
		else $error("pending transaction with no results");

	a_ptr_covers: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s1 |-> job_s1.ptr >= step)
		else $error("bit pointer below one unit");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s1 |-> job_s1.cnt <= 3'd4)
		else $error("more than four results pending");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> !busy)
		else $error("new transaction overwrote pending results");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		last_move && !job_valid |=> !job_valid_s1)
		else $error("pending transaction kept after final result");

endmodule

@@ hw/rtl/bit_field_repacker_top.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// item      in         item_valid / item_stall      item (data_in, block_start)
// result    out        result_valid / result_stall  result (data_out, last)
// cfg       in         cfg_we                       cfg_index, cfg_data
//
// unpack: one input byte per cycle while item_stall is low, 0 or 1 element out
// pack: 1 to 4 bytes per element, one byte per cycle through the result register
// while result_stall is low; no new element is taken until the last byte of the current one moves
// results go through the job register and then the result register after a transaction is accepted
// reset clears accumulator, bit count and config (unpack, width 20)
// item_stall rises while earlier results are still draining; result_stall freezes it

module bit_field_repacker_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic item_valid,
	output logic item_stall,
	input  bfr_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output bfr_pkg::result_t result
);

	logic job_valid;
	bfr_pkg::job_t job;
	logic busy;

	assign item_stall = busy;

	bfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.job_valid(job_valid),
		.job(job)
	);

	bfr_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(job),
		.busy(busy),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

@@ dv/bit_field_repacker_top_tb.sv @@
`timescale 1ns / 1ps

module bit_field_repacker_top_tb;
	import bfr_pkg::*;

	localparam logic MODE_UNPACK = 1'b0;
	localparam logic MODE_PACK = 1'b1;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 100;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned PHASE_ITEMS = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	item_t pending_items[$];
	result_t expected_results[$];

	logic [ACC_W-1:0] pred_acc = '0;
	logic [HELD_W-1:0] pred_held = '0;
	logic pred_mode = MODE_UNPACK;
	logic [EW_W-1:0] pred_width = ELEM_RESET;

	logic steady = 1'b0;
	int mismatch_count = 0;
	int results_checked = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int quiet = 0;
	result_t oldest_result;

	bit_field_repacker_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic predict_repack(input item_t it);
		logic [EW_W-1:0] w;
		logic [ACC_W-1:0] msk;
		result_t r;
		int n;
		w = pred_width;
		if (w < MIN_ELEM) begin
			w = MIN_ELEM;
		end else if (w > MAX_ELEM) begin
			w = MAX_ELEM;
		end
		msk = (32'd1 << w) - 32'd1;
		if (it.block_start) begin
			pred_acc = '0;
			pred_held = '0;
		end
		if (pred_mode == MODE_UNPACK) begin
			pred_acc = (pred_acc << BYTE_BITS) | 32'(it.data_in & BYTE_MASK);
			pred_held = pred_held + BYTE_BITS;
			if (pred_held > ACC_FULL) begin
				pred_held = ACC_FULL;
			end
			if (pred_held >= w) begin
				pred_held = pred_held - w;
				r.data_out = DATA_W'((pred_acc >> pred_held) & msk);
				r.last = 1'b1;
				expected_results.push_back(r);
			end
		end else begin
			pred_acc = (pred_acc << w) | (32'(it.data_in) & msk);
			pred_held = pred_held + w;
			if (pred_held > ACC_FULL) begin
				pred_held = ACC_FULL;
			end
			n = 0;
			while (pred_held >= BYTE_BITS && n < 4) begin
				pred_held = pred_held - BYTE_BITS;
				n++;
				r.data_out = DATA_W'((pred_acc >> pred_held) & 32'(BYTE_MASK));
				r.last = !(pred_held >= BYTE_BITS && n < 4);
				expected_results.push_back(r);
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_repack(item);
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
			results_checked <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result data_out=%h last=%b",
						result.data_out, result.last));
				end else begin
					oldest_result = expected_results.pop_front();
					if (result.data_out !== oldest_result.data_out) begin
						report_mismatch($sformatf("data_out got %h want %h",
							result.data_out, oldest_result.data_out));
					end
					if (result.last !== oldest_result.last) begin
						report_mismatch($sformatf("last got %b want %b (data_out %h)",
							result.last, oldest_result.last, oldest_result.data_out));
					end
				end
				results_checked <= results_checked + 1;
			end
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && !steady && pending_items.size() > 20
					&& results_checked > 30) begin
				// long hold-off so the block backs up into its input
				result_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				result_stall <= !steady && ($urandom_range(0, 99) < 21);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PACK_MODE) begin
			pred_mode = val[0];
		end else begin
			pred_width = val;
		end
	endtask

	task automatic push_item(input logic [DATA_W-1:0] d, input logic bs);
		item_t it;
		it.data_in = d;
		it.block_start = bs;
		pending_items.push_back(it);
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_random(input logic mode, input logic bs);
		logic [DATA_W-1:0] d;
		d = DATA_W'($urandom());
		// unpack mostly sees clean bytes, sometimes junk above bit 7
		if (mode == MODE_UNPACK && $urandom_range(0, 7) != 0) begin
			d = d & BYTE_MASK;
		end
		push_item(d, bs);
	endtask

	task automatic run_random(input logic mode, input logic [EW_W-1:0] width, input int count);
		int made;
		int len;
		int k;
		write_cfg(CFG_PACK_MODE, {4'($urandom_range(0, 15)), mode});
		write_cfg(CFG_ELEMENT_BITS, width);
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(1, 10);
				for (k = 0; k < len; k++) begin
					push_random(mode, k == 0);
					made++;
				end
			end else begin
				push_random(mode, 1'($urandom_range(0, 1)));
				made++;
			end
		end
		drain();
	endtask

	initial begin
		int p;
		logic [EW_W-1:0] w;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unpack, width 20
		push_item(25'h00000FF, 1'b1);
		push_item(25'h0000000, 1'b0);
		push_item(25'h1FFFFA5, 1'b0);
		push_item(25'h1000000, 1'b0);
		push_item(25'h000003C, 1'b0);
		drain();

		// pack, widest element, upper bits of the mode write set
		write_cfg(CFG_PACK_MODE, 5'h1F);
		write_cfg(CFG_ELEMENT_BITS, 5'd25);
		push_item(25'h1FFFFFF, 1'b1);
		push_item(25'h0000000, 1'b0);
		push_item(25'h1555555, 1'b0);
		push_item(25'h0AAAAAA, 1'b0);
		drain();

		// width below range saturates to 8, excess element bits masked
		write_cfg(CFG_ELEMENT_BITS, 5'd0);
		push_item(25'h1FFFF5A, 1'b1);
		push_item(25'h0000000, 1'b0);
		drain();

		// width above range saturates to 25
		write_cfg(CFG_ELEMENT_BITS, 5'd31);
		push_item(25'h1ABCDEF, 1'b0);
		drain();

		write_cfg(CFG_ELEMENT_BITS, 5'd13);
		push_item(25'h1FFFFFF, 1'b1);
		push_item(25'h0001234, 1'b0);
		push_item(25'h0000ABC, 1'b1);
		drain();

		// mode change mid-block, accumulator overflows and saturates
		write_cfg(CFG_PACK_MODE, 5'h1E);
		write_cfg(CFG_ELEMENT_BITS, 5'd25);
		push_item(25'h0000011, 1'b1);
		push_item(25'h0000022, 1'b0);
		push_item(25'h1FFFF33, 1'b0);
		drain();
		write_cfg(CFG_PACK_MODE, 5'h01);
		push_item(25'h1FFFFFF, 1'b0);
		drain();

		write_cfg(CFG_PACK_MODE, 5'h00);
		write_cfg(CFG_ELEMENT_BITS, 5'd8);
		push_item(25'h0000000, 1'b1);
		push_item(25'h00000FF, 1'b0);
		drain();

		for (p = 0; p < 8; p++) begin
			case (p)
				0: w = 5'd25;
				1, 2: w = 5'd8;
				3: w = 5'd25;
				4, 5: w = 5'($urandom_range(8, 25));
				default: w = 5'($urandom_range(0, 31));
			endcase
			steady = (p == 0);
			run_random((p % 2 == 0) ? MODE_PACK : MODE_UNPACK, w, PHASE_ITEMS);
		end
		steady = 1'b0;

		drain();
		if (expected_results.size() != 0) begin
			report_mismatch("results still outstanding at end");
		end
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ bit_field_repacker_top.f @@
hw/rtl/bfr_pkg.sv
hw/rtl/bfr_front.sv
hw/rtl/bfr_emit.sv
hw/rtl/bit_field_repacker_top.sv
dv/bit_field_repacker_top_tb.sv
